// ===== rtl/core/wete_pkg.sv =====
// Shared types and codes for the weighted edge table engine.
`default_nettype none
package wete_pkg;

  localparam logic [2:0] REQ_ADD_NODE  = 3'd0;
  localparam logic [2:0] REQ_DEL_NODE  = 3'd1;
  localparam logic [2:0] REQ_ADD_EDGE  = 3'd2;
  localparam logic [2:0] REQ_DEL_EDGE  = 3'd3;
  localparam logic [2:0] REQ_FIND_EDGE = 3'd4;
  localparam logic [2:0] REQ_CLEAR     = 3'd5;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NODE_MISSING = 3'd1,
    ST_NODE_EXISTS  = 3'd2,
    ST_END_MISSING  = 3'd3,
    ST_EDGE_MISSING = 3'd4,
    ST_SELF_LOOP    = 3'd5,
    ST_FULL         = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_FINISH,
    S_WRD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] src;
    logic [7:0] dst;
  } ent_t;

  typedef struct packed {
    logic hit_pair;
    logic hit_node;
    logic slot_free;
  } match_t;

endpackage
`default_nettype wire

// ===== rtl/core/wete_match.sv =====
// Entry compare unit shared by every table scan.
`default_nettype none
module wete_match (
  input  wete_pkg::ent_t   entry,
  input  logic [7:0]       node_a,
  input  logic [7:0]       node_b,
  output wete_pkg::match_t hit
);
  logic src_eq;
  logic dst_eq_b;
  logic dst_eq_a;

  assign src_eq   = (entry.src == node_a);
  assign dst_eq_b = (entry.dst == node_b);
  assign dst_eq_a = (entry.dst == node_a);

  assign hit.hit_pair  = entry.valid & src_eq & dst_eq_b;
  assign hit.hit_node  = entry.valid & (src_eq | dst_eq_a);
  assign hit.slot_free = ~entry.valid;
endmodule
`default_nettype wire

// ===== rtl/core/weighted_edge_table_engine_core.sv =====
// Top level of the weighted edge table engine: sequencer, stores and counters.
// Usage:
//   Requests enter on in_* (valid/stall); one result word leaves on out_*
//   per request. in_stall is low only while the engine is idle, so one
//   request is in flight at a time.
//   Node add, rejected requests and unused kinds go from decode straight to the result.
//   Remove node, add/remove/lookup edge walk the whole edge table through one
//   read port, one entry a cycle.
//   Clear sweeps the table with one write a cycle.
//   After reset a clearing pass invalidates the edge table; in_stall stays
//   high until it ends. Node bits and counts reset at once.
//   The result sits in an output register; while out_stall is high the
//   word holds and the engine waits with the next result before going idle.
//   weight_out is the stored weight of an edge found by lookup or remove, zero-extended to 64 bits; else zero.
`default_nettype none
module weighted_edge_table_engine_core #(
  parameter int NODE_SLOTS   = 256,
  parameter int EDGE_SLOTS   = 1024,
  parameter int WEIGHT_WIDTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [7:0]  in_from_node,
  input  wire logic [7:0]  in_to_node,
  input  wire logic [63:0] in_weight_bits,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic             out_edge_found,
  output logic [63:0]      out_weight_out,
  output logic [8:0]       out_node_count,
  output logic [10:0]      out_edge_count
);
  localparam int NP  = (NODE_SLOTS < 256) ? NODE_SLOTS : 256;
  localparam int NAW = $clog2(NP);
  localparam int EAW = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1;
  localparam int ECW = $clog2(EDGE_SLOTS + 1);
  localparam logic [EAW-1:0] LAST = EAW'(EDGE_SLOTS - 1);

  wete_pkg::state_t state_r, state_nxt;

  // request word
  logic [2:0]              kind_r, kind_nxt;
  logic [7:0]              a_r, a_nxt;
  logic [7:0]              b_r, b_nxt;
  logic [WEIGHT_WIDTH-1:0] w_r, w_nxt;

  logic [NP-1:0]  node_present_r, node_present_nxt;
  logic [8:0]     nodes_held_r, nodes_held_nxt;
  logic [ECW-1:0] edges_held_r, edges_held_nxt;
  logic           init_r, init_nxt;

  // scan pipeline
  logic [EAW-1:0] rd_addr_r, rd_addr_nxt;
  logic           issued_all_r, issued_all_nxt;
  logic           chk_vld_r, chk_vld_nxt;
  logic [EAW-1:0] chk_addr_r, chk_addr_nxt;
  logic           found_r, found_nxt;
  logic [EAW-1:0] slot_r, slot_nxt;
  logic           free_found_r, free_found_nxt;
  logic [EAW-1:0] free_slot_r, free_slot_nxt;

  wete_pkg::status_t       status_r, status_nxt;
  logic [WEIGHT_WIDTH-1:0] wout_r, wout_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [2:0]              o_status_r, o_status_nxt;
  logic                    o_found_r, o_found_nxt;
  logic [63:0]             o_weight_r, o_weight_nxt;
  logic [8:0]              o_nodes_r, o_nodes_nxt;
  logic [10:0]             o_edges_r, o_edges_nxt;

  // memories
  wete_pkg::ent_t          ent_mem [EDGE_SLOTS];
  logic [WEIGHT_WIDTH-1:0] wt_mem  [EDGE_SLOTS];
  wete_pkg::ent_t          ent_rd_r;
  logic [WEIGHT_WIDTH-1:0] wt_rd_r;
  logic                    ent_we;
  logic [EAW-1:0]          ent_waddr;
  wete_pkg::ent_t          ent_wdata;
  logic                    wt_we;
  logic [EAW-1:0]          wt_addr;

  wete_pkg::match_t hit;
  logic             a_in_range, b_in_range, a_present, b_present;
  logic [31:0]      edges32;

  wete_match u_match (
    .entry  (ent_rd_r),
    .node_a (a_r),
    .node_b (b_r),
    .hit    (hit)
  );

  assign a_in_range = (32'(a_r) < NODE_SLOTS);
  assign b_in_range = (32'(b_r) < NODE_SLOTS);
  assign a_present  = a_in_range && node_present_r[a_r[NAW-1:0]];
  assign b_present  = b_in_range && node_present_r[b_r[NAW-1:0]];
  assign edges32    = 32'(edges_held_nxt);

  assign in_stall       = (state_r != wete_pkg::S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = o_status_r;
  assign out_edge_found = o_found_r;
  assign out_weight_out = o_weight_r;
  assign out_node_count = o_nodes_r;
  assign out_edge_count = o_edges_r;

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    ent_rd_r <= ent_mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (wt_we) wt_mem[wt_addr] <= w_r;
    wt_rd_r <= wt_mem[wt_addr];
  end

  always_comb begin
    state_nxt        = state_r;
    kind_nxt         = kind_r;
    a_nxt            = a_r;
    b_nxt            = b_r;
    w_nxt            = w_r;
    node_present_nxt = node_present_r;
    nodes_held_nxt   = nodes_held_r;
    edges_held_nxt   = edges_held_r;
    init_nxt         = init_r;
    rd_addr_nxt      = rd_addr_r;
    issued_all_nxt   = issued_all_r;
    chk_vld_nxt      = 1'b0;
    chk_addr_nxt     = rd_addr_r;
    found_nxt        = found_r;
    slot_nxt         = slot_r;
    free_found_nxt   = free_found_r;
    free_slot_nxt    = free_slot_r;
    status_nxt       = status_r;
    wout_nxt         = wout_r;
    out_valid_nxt    = out_valid_r;
    o_status_nxt     = o_status_r;
    o_found_nxt      = o_found_r;
    o_weight_nxt     = o_weight_r;
    o_nodes_nxt      = o_nodes_r;
    o_edges_nxt      = o_edges_r;
    ent_we           = 1'b0;
    ent_waddr        = chk_addr_r;
    ent_wdata        = '{valid: 1'b0, src: a_r, dst: b_r};
    wt_we            = 1'b0;
    wt_addr          = slot_r;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      wete_pkg::S_CLEAR: begin
        ent_we      = 1'b1;
        ent_waddr   = rd_addr_r;
        rd_addr_nxt = rd_addr_r + 1'b1;
        if (rd_addr_r == LAST) begin
          rd_addr_nxt = '0;
          init_nxt    = 1'b0;
          state_nxt   = init_r ? wete_pkg::S_IDLE : wete_pkg::S_DONE;
        end
      end
      wete_pkg::S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_req_type;
          a_nxt     = in_from_node;
          b_nxt     = in_to_node;
          w_nxt     = in_weight_bits[WEIGHT_WIDTH-1:0];
          state_nxt = wete_pkg::S_DECIDE;
        end
      end
      wete_pkg::S_DECIDE: begin
        status_nxt     = wete_pkg::ST_OK;
        wout_nxt       = '0;
        found_nxt      = 1'b0;
        free_found_nxt = 1'b0;
        rd_addr_nxt    = '0;
        issued_all_nxt = 1'b0;
        state_nxt      = wete_pkg::S_DONE;
        case (kind_r)
          wete_pkg::REQ_ADD_NODE: begin
            if (!a_in_range) begin
              status_nxt = wete_pkg::ST_FULL;
            end else if (a_present) begin
              status_nxt = wete_pkg::ST_NODE_EXISTS;
            end else begin
              node_present_nxt[a_r[NAW-1:0]] = 1'b1;
              nodes_held_nxt = nodes_held_r + 9'd1;
            end
          end
          wete_pkg::REQ_DEL_NODE: begin
            if (!a_present) status_nxt = wete_pkg::ST_NODE_MISSING;
            else            state_nxt  = wete_pkg::S_SCAN;
          end
          wete_pkg::REQ_ADD_EDGE, wete_pkg::REQ_DEL_EDGE, wete_pkg::REQ_FIND_EDGE: begin
            if (!a_present || !b_present)
              status_nxt = wete_pkg::ST_END_MISSING;
            else if (kind_r == wete_pkg::REQ_ADD_EDGE && a_r == b_r)
              status_nxt = wete_pkg::ST_SELF_LOOP;
            else
              state_nxt = wete_pkg::S_SCAN;
          end
          wete_pkg::REQ_CLEAR: begin
            node_present_nxt = '0;
            nodes_held_nxt   = '0;
            edges_held_nxt   = '0;
            state_nxt        = wete_pkg::S_CLEAR;
          end
          default: ;
        endcase
      end
      wete_pkg::S_SCAN: begin
        // the compare checks the entry whose read was issued in the previous cycle
        if (!issued_all_r) begin
          chk_vld_nxt = 1'b1;
          rd_addr_nxt = rd_addr_r + 1'b1;
          if (rd_addr_r == LAST) issued_all_nxt = 1'b1;
        end
        if (chk_vld_r) begin
          if (kind_r == wete_pkg::REQ_DEL_NODE) begin
            if (hit.hit_node) begin
              ent_we         = 1'b1;
              edges_held_nxt = edges_held_r - 1'b1;
            end
          end else begin
            if (hit.hit_pair && !found_r) begin
              found_nxt = 1'b1;
              slot_nxt  = chk_addr_r;
            end
            if (hit.slot_free && !free_found_r) begin
              free_found_nxt = 1'b1;
              free_slot_nxt  = chk_addr_r;
            end
          end
          if (chk_addr_r == LAST) state_nxt = wete_pkg::S_FINISH;
        end
      end
      wete_pkg::S_FINISH: begin
        state_nxt = wete_pkg::S_DONE;
        case (kind_r)
          wete_pkg::REQ_DEL_NODE: begin
            node_present_nxt[a_r[NAW-1:0]] = 1'b0;
            nodes_held_nxt = nodes_held_r - 9'd1;
          end
          wete_pkg::REQ_ADD_EDGE: begin
            if (found_r) begin
              wt_we = 1'b1;
            end else if (free_found_r) begin
              ent_we          = 1'b1;
              ent_waddr       = free_slot_r;
              ent_wdata.valid = 1'b1;
              wt_we           = 1'b1;
              wt_addr         = free_slot_r;
              edges_held_nxt  = edges_held_r + 1'b1;
            end else begin
              status_nxt = wete_pkg::ST_FULL;
            end
          end
          default: begin
            if (!found_r) begin
              status_nxt = wete_pkg::ST_EDGE_MISSING;
            end else begin
              state_nxt = wete_pkg::S_WRD;
              if (kind_r == wete_pkg::REQ_DEL_EDGE) begin
                ent_we         = 1'b1;
                ent_waddr      = slot_r;
                edges_held_nxt = edges_held_r - 1'b1;
              end
            end
          end
        endcase
      end
      wete_pkg::S_WRD: begin
        wout_nxt  = wt_rd_r;
        state_nxt = wete_pkg::S_DONE;
      end
      wete_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = status_r;
          o_found_nxt   = found_r &&
                          (kind_r inside {wete_pkg::REQ_ADD_EDGE, wete_pkg::REQ_DEL_EDGE,
                                          wete_pkg::REQ_FIND_EDGE});
          o_weight_nxt  = 64'(wout_r);
          o_nodes_nxt   = nodes_held_r;
          o_edges_nxt   = edges32[10:0];
          state_nxt     = wete_pkg::S_IDLE;
        end
      end
      default: state_nxt = wete_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= wete_pkg::S_CLEAR;
      init_r         <= 1'b1;
      rd_addr_r      <= '0;
      node_present_r <= '0;
      nodes_held_r   <= '0;
      edges_held_r   <= '0;
      out_valid_r    <= 1'b0;
      chk_vld_r      <= 1'b0;
      issued_all_r   <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      init_r         <= init_nxt;
      rd_addr_r      <= rd_addr_nxt;
      node_present_r <= node_present_nxt;
      nodes_held_r   <= nodes_held_nxt;
      edges_held_r   <= edges_held_nxt;
      out_valid_r    <= out_valid_nxt;
      chk_vld_r      <= chk_vld_nxt;
      issued_all_r   <= issued_all_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    w_r          <= w_nxt;
    chk_addr_r   <= chk_addr_nxt;
    found_r      <= found_nxt;
    slot_r       <= slot_nxt;
    free_found_r <= free_found_nxt;
    free_slot_r  <= free_slot_nxt;
    status_r     <= status_nxt;
    wout_r       <= wout_nxt;
    o_status_r   <= o_status_nxt;
    o_found_r    <= o_found_nxt;
    o_weight_r   <= o_weight_nxt;
    o_nodes_r    <= o_nodes_nxt;
    o_edges_r    <= o_edges_nxt;
  end

  a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    edges_held_r <= ECW'(EDGE_SLOTS))
    else $error("edge count beyond table size");

  a_node_count: assert property (@(posedge clk) disable iff (!rst_n)
    32'(nodes_held_r) == 32'($countones(node_present_r)))
    else $error("node count out of step with presence map");

  a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == wete_pkg::S_DECIDE))
    else $error("accepted word not decoded");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wete_pkg::S_IDLE) |-> (!ent_we && !wt_we))
    else $error("table write while idle");

endmodule
`default_nettype wire
